// File: sv/tvf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tvf_pkg;

  localparam int POS_W    = 32;
  localparam int DIST_W   = 32;
  localparam int SPC_W    = 25;
  localparam int LIM_W    = 35;
  localparam int B_W      = 24;
  localparam int NODE_W   = 3 * B_W;
  localparam int FRAC_W   = 16;
  localparam int WGT_W    = FRAC_W + 1;
  localparam int STORE_AW = 15;
  localparam int STORE_DEPTH = 1 << STORE_AW;
  localparam int CFG_IW   = 3;

  localparam logic [SPC_W-1:0] SPACING_RESET = SPC_W'(256);

  // Register indexes of the configuration port.
  localparam logic [CFG_IW-1:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_ORIGIN_Z  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_SPACING_X = 3'd3;
  localparam logic [CFG_IW-1:0] REG_SPACING_Y = 3'd4;
  localparam logic [CFG_IW-1:0] REG_SPACING_Z = 3'd5;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef logic [2:0][SPC_W-1:0] spacing_t;

  // One classified item as it waits between front and back.
  typedef struct packed {
    logic                       action;
    logic                       in_grid;
    logic [2:0][DIST_W-1:0]     offs;
    logic [STORE_AW-1:0]        node_index;
    logic [NODE_W-1:0]          node_b;
  } fq_t;

endpackage

`default_nettype wire

// File: sv/tvf_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tvf_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/tvf_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tvf_front #(
  parameter int GRID_X = 32,
  parameter int GRID_Y = 32,
  parameter int GRID_Z = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        action,
  input  wire logic [tvf_pkg::POS_W-1:0]   pos_x,
  input  wire logic [tvf_pkg::POS_W-1:0]   pos_y,
  input  wire logic [tvf_pkg::POS_W-1:0]   pos_z,
  input  wire logic [tvf_pkg::STORE_AW-1:0] node_index,
  input  wire logic [tvf_pkg::B_W-1:0]     node_bx,
  input  wire logic [tvf_pkg::B_W-1:0]     node_by,
  input  wire logic [tvf_pkg::B_W-1:0]     node_bz,
  input  wire logic                        cfg_valid,
  input  wire logic [tvf_pkg::CFG_IW-1:0]  cfg_index,
  input  wire logic [tvf_pkg::POS_W-1:0]   cfg_data,
  output tvf_pkg::spacing_t                spacing_eff,
  output tvf_pkg::fq_t                     head,
  output logic                             head_valid,
  input  wire logic                        pop
);

  import tvf_pkg::*;

  logic [2:0][POS_W-1:0] pos_v;
  logic [2:0][POS_W-1:0] origin;
  logic [2:0][SPC_W-1:0] spacing;
  logic [2:0][LIM_W-1:0] lim;
  logic [2:0][POS_W:0]   diff;
  logic [2:0]            in_ax;
  fq_t                   ent_in;
  fq_t                   ent [2];
  logic                  wptr;
  logic                  rptr;
  logic [1:0]            cnt;
  logic                  push;

  assign pos_v[0] = pos_x;
  assign pos_v[1] = pos_y;
  assign pos_v[2] = pos_z;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    localparam int NA = (a == 0) ? GRID_X : ((a == 1) ? GRID_Y : GRID_Z);

    // A spacing of zero behaves as one.
    assign spacing_eff[a] = (spacing[a] == '0) ? SPC_W'(1) : spacing[a];
    assign diff[a] = {pos_v[a][POS_W-1], pos_v[a]} - {origin[a][POS_W-1], origin[a]};
    assign in_ax[a] = !diff[a][POS_W] && (LIM_W'(diff[a][DIST_W-1:0]) <= lim[a]);

    // Upper bound of the grid along this axis, following the spacing at once.
    assign lim[a] = LIM_W'(NA - 1) * LIM_W'(spacing_eff[a]);

    assign ent_in.offs[a] = diff[a][DIST_W-1:0];
  end

  assign ent_in.action     = action;
  assign ent_in.in_grid    = &in_ax;
  assign ent_in.node_index = node_index;
  assign ent_in.node_b     = {node_bx, node_by, node_bz};

  always_ff @(posedge clk) begin
    if (rst) begin
      origin  <= '0;
      spacing <= {3{SPACING_RESET}};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ORIGIN_X:  origin[0]  <= cfg_data;
        REG_ORIGIN_Y:  origin[1]  <= cfg_data;
        REG_ORIGIN_Z:  origin[2]  <= cfg_data;
        REG_SPACING_X: spacing[0] <= cfg_data[SPC_W-1:0];
        REG_SPACING_Y: spacing[1] <= cfg_data[SPC_W-1:0];
        REG_SPACING_Z: spacing[2] <= cfg_data[SPC_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy       = (cnt == 2'd2);
  assign push       = start && !busy;
  assign head_valid = (cnt != 2'd0);
  assign head       = ent[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wptr] <= ent_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      wptr <= 1'b0;
      rptr <= 1'b0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop && head_valid) begin
        rptr <= ~rptr;
      end
      cnt <= cnt + 2'(push) - 2'(pop && head_valid);
    end
  end

endmodule

`default_nettype wire

// File: sv/tvf_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider: q = floor(d * 2^16 / h), one quotient bit per stage.
// Valid for d < 2^QW * h, which holds for every point inside the grid.
module tvf_div #(
  parameter int QW = 5
) (
  input  wire logic                        clk,
  input  wire logic [tvf_pkg::DIST_W-1:0]  d,
  input  wire logic [tvf_pkg::SPC_W-1:0]   h,
  output logic      [QW+tvf_pkg::FRAC_W-1:0] q
);

  import tvf_pkg::*;

  localparam int S = QW + FRAC_W;

  logic [SPC_W-1:0] rem_q [S+1];
  logic [QW-1:0]    low_q [S+1];
  logic [S-1:0]     quo_q [S+1];

  always_ff @(posedge clk) begin
    rem_q[0] <= SPC_W'(d >> QW);
    low_q[0] <= d[QW-1:0];
    quo_q[0] <= '0;
  end

  for (genvar s = 0; s < S; s++) begin : g_stage
    logic [SPC_W:0] rin;
    logic           ge;

    assign rin = {rem_q[s], low_q[s][QW-1]};
    assign ge  = (rin >= {1'b0, h});

    always_ff @(posedge clk) begin
      rem_q[s+1] <= ge ? SPC_W'(rin - {1'b0, h}) : SPC_W'(rin);
      low_q[s+1] <= low_q[s] << 1;
      quo_q[s+1] <= {quo_q[s][S-2:0], ge};
    end
  end

  assign q = quo_q[S];

endmodule

`default_nettype wire

// File: sv/tvf_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tvf_back #(
  parameter int GRID_X = 32,
  parameter int GRID_Y = 32,
  parameter int GRID_Z = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     head_valid,
  input  tvf_pkg::fq_t                  head,
  input  tvf_pkg::spacing_t             spacing_eff,
  output logic                          pop,
  output logic                          done,
  output logic                          inside_res,
  output logic [tvf_pkg::B_W-1:0]       out_bx,
  output logic [tvf_pkg::B_W-1:0]       out_by,
  output logic [tvf_pkg::B_W-1:0]       out_bz
);

  import tvf_pkg::*;

  localparam int GMAX = (GRID_X > GRID_Y) ? ((GRID_X > GRID_Z) ? GRID_X : GRID_Z)
                                          : ((GRID_Y > GRID_Z) ? GRID_Y : GRID_Z);
  localparam int QW   = $clog2(GMAX);
  localparam int S    = QW + FRAC_W;
  localparam int VY_W = 41;
  localparam int Y_W  = 58;

  typedef struct packed {
    logic                action;
    logic                in_grid;
    logic [STORE_AW-1:0] node_index;
    logic [NODE_W-1:0]   node_b;
  } side_t;

  side_t side_q [S+1];
  logic  vld_q  [S+1];

  logic [2:0][S-1:0] quo;

  assign pop = head_valid;

  for (genvar a = 0; a < 3; a++) begin : g_div
    tvf_div #(.QW(QW)) u_div (
      .clk (clk),
      .d   (head.offs[a]),
      .h   (spacing_eff[a]),
      .q   (quo[a])
    );
  end

  // Side data travels alongside the divider stages.
  always_ff @(posedge clk) begin
    side_q[0] <= '{action: head.action, in_grid: head.in_grid,
                   node_index: head.node_index, node_b: head.node_b};
    for (int s = 0; s < S; s++) begin
      side_q[s+1] <= side_q[s];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= S; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else begin
      vld_q[0] <= head_valid;
      for (int s = 0; s < S; s++) begin
        vld_q[s+1] <= vld_q[s];
      end
    end
  end

  // Cell index and fraction; the upper face falls into the last cell with full weight.
  logic [2:0][QW-1:0]    cidx;
  logic [2:0][WGT_W-1:0] frac;

  for (genvar a = 0; a < 3; a++) begin : g_cell
    localparam int NA = (a == 0) ? GRID_X : ((a == 1) ? GRID_Y : GRID_Z);
    logic [QW-1:0] qi;
    assign qi = quo[a][S-1:FRAC_W];
    assign cidx[a] = (qi == QW'(NA - 1)) ? QW'(NA - 2) : qi;
    assign frac[a] = (qi == QW'(NA - 1)) ? WGT_W'(1 << FRAC_W)
                                         : {1'b0, quo[a][FRAC_W-1:0]};
  end

  logic [STORE_AW-1:0] base_row;
  assign base_row = STORE_AW'(cidx[0]) * STORE_AW'(GRID_Y) + STORE_AW'(cidx[1]);

  logic                  v1, v2, v3, v4, v5;
  side_t                 s1, s2, s3, s4, s5;
  logic [STORE_AW-1:0]   base1;
  logic [2:0][WGT_W-1:0] t1, t2, t3, t4, t5;

  always_ff @(posedge clk) begin
    base1 <= STORE_AW'(base_row * STORE_AW'(GRID_Z)) + STORE_AW'(cidx[2]);
    t1    <= frac;
    s1    <= side_q[S];
    t2    <= t1;
    s2    <= s1;
    t3    <= t2;
    s3    <= s2;
    t4    <= t3;
    s4    <= s3;
    t5    <= t4;
    s5    <= s4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= vld_q[S];
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Eight copies of the store, one per cell corner; corner k = 4*dx + 2*dy + dz.
  logic [NODE_W-1:0] rdata [8];
  logic              we;

  assign we = v1 && (s1.action == ACT_LOAD);

  for (genvar k = 0; k < 8; k++) begin : g_corner
    localparam int OFF = ((((k >> 2) & 1) * GRID_Y + ((k >> 1) & 1)) * GRID_Z + (k & 1))
                         % STORE_DEPTH;
    tvf_ram #(.WIDTH(NODE_W), .DEPTH(STORE_DEPTH)) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (s1.node_index),
      .wdata (s1.node_b),
      .raddr (base1 + STORE_AW'(OFF)),
      .rdata (rdata[k])
    );
  end

  // Blend along z, then y, then x; each multiply stage is registered.
  logic signed [VY_W-1:0] vy   [3][2][2];
  logic signed [Y_W-1:0]  y32  [3][2];
  logic signed [Y_W-1:0]  x32  [3];

  logic signed [WGT_W:0] wz0, wz1, wy0, wy1, wx0, wx1;
  assign wz1 = $signed({1'b0, t2[2]});
  assign wz0 = $signed({1'b0, WGT_W'(1 << FRAC_W) - t2[2]});
  assign wy1 = $signed({1'b0, t3[1]});
  assign wy0 = $signed({1'b0, WGT_W'(1 << FRAC_W) - t3[1]});
  assign wx1 = $signed({1'b0, t4[0]});
  assign wx0 = $signed({1'b0, WGT_W'(1 << FRAC_W) - t4[0]});

  for (genvar c = 0; c < 3; c++) begin : g_comp
    for (genvar dx = 0; dx < 2; dx++) begin : g_dx
      logic signed [Y_W-1:0]  ysum;
      logic signed [VY_W-1:0] vx;

      for (genvar dy = 0; dy < 2; dy++) begin : g_dy
        logic signed [B_W-1:0] b0, b1;
        assign b0 = $signed(rdata[dx*4 + dy*2][(2-c)*B_W +: B_W]);
        assign b1 = $signed(rdata[dx*4 + dy*2 + 1][(2-c)*B_W +: B_W]);
        always_ff @(posedge clk) begin
          vy[c][dx][dy] <= VY_W'(b0) * VY_W'(wz0) + VY_W'(b1) * VY_W'(wz1);
        end
      end

      always_ff @(posedge clk) begin
        y32[c][dx] <= Y_W'(vy[c][dx][0]) * Y_W'(wy0) + Y_W'(vy[c][dx][1]) * Y_W'(wy1);
      end

      assign ysum = y32[c][dx] + Y_W'(1 << (FRAC_W - 1));
      assign vx   = ysum[VY_W+FRAC_W-1:FRAC_W];
    end

    always_ff @(posedge clk) begin
      x32[c] <= Y_W'(g_dx[0].vx) * Y_W'(wx0) + Y_W'(g_dx[1].vx) * Y_W'(wx1);
    end
  end

  logic [2:0][Y_W-1:0] xr;
  for (genvar c = 0; c < 3; c++) begin : g_round
    assign xr[c] = x32[c] + Y_W'(64'd1 << 31);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v5 && (s5.action == ACT_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    inside_res <= s5.in_grid;
    out_bx     <= s5.in_grid ? xr[0][B_W+31:32] : '0;
    out_by     <= s5.in_grid ? xr[1][B_W+31:32] : '0;
    out_bz     <= s5.in_grid ? xr[2][B_W+31:32] : '0;
  end

endmodule

`default_nettype wire

// File: sv/trilinear_vector_field_lookup_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Handshake            | Payload
// ----------+----------------------+-------------------------------------------------
// item in   | start, busy          | action, pos_x/y/z, node_index, node_bx/by/bz
// result    | done (one-cycle)     | inside_res, out_bx, out_by, out_bz
// config    | cfg_valid, cfg_ready | cfg_index, cfg_data
//
// One item is taken every cycle while busy is low; a query result goes through the queue,
// the bit-per-stage divider, the store address and read, three blend stages and output register.
// Loads produce no result and are written to the store in order with queries.
// rst is synchronous; it resets the config registers and control state, not the data pipeline or the node store.
// Results cannot be held off; busy rises only if the two-entry queue fills.
module trilinear_vector_field_lookup_unit #(
  parameter int GRID_X = 32,
  parameter int GRID_Y = 32,
  parameter int GRID_Z = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         action,
  input  wire logic [tvf_pkg::POS_W-1:0]    pos_x,
  input  wire logic [tvf_pkg::POS_W-1:0]    pos_y,
  input  wire logic [tvf_pkg::POS_W-1:0]    pos_z,
  input  wire logic [tvf_pkg::STORE_AW-1:0] node_index,
  input  wire logic [tvf_pkg::B_W-1:0]      node_bx,
  input  wire logic [tvf_pkg::B_W-1:0]      node_by,
  input  wire logic [tvf_pkg::B_W-1:0]      node_bz,
  output logic                              done,
  output logic                              inside_res,
  output logic [tvf_pkg::B_W-1:0]           out_bx,
  output logic [tvf_pkg::B_W-1:0]           out_by,
  output logic [tvf_pkg::B_W-1:0]           out_bz,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [tvf_pkg::CFG_IW-1:0]   cfg_index,
  input  wire logic [tvf_pkg::POS_W-1:0]    cfg_data
);

  import tvf_pkg::*;

  spacing_t spacing_eff;
  fq_t      head;
  logic     head_valid;
  logic     pop;

  assign cfg_ready = 1'b1;

  tvf_front #(.GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z)) u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .node_index  (node_index),
    .node_bx     (node_bx),
    .node_by     (node_by),
    .node_bz     (node_bz),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .spacing_eff (spacing_eff),
    .head        (head),
    .head_valid  (head_valid),
    .pop         (pop)
  );

  tvf_back #(.GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z)) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .spacing_eff (spacing_eff),
    .pop         (pop),
    .done        (done),
    .inside_res  (inside_res),
    .out_bx      (out_bx),
    .out_by      (out_by),
    .out_bz      (out_bz)
  );

endmodule

`default_nettype wire

// File: tb/sv/trilinear_vector_field_lookup_unit_tb.sv
`timescale 1ns / 1ps

module trilinear_vector_field_lookup_unit_tb;
  import tvf_pkg::*;

  localparam int NX = 32;
  localparam int NY = 32;
  localparam int NZ = 32;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic            in_grid;
    logic [B_W-1:0]  bx;
    logic [B_W-1:0]  by;
    logic [B_W-1:0]  bz;
  } field_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic action = ACT_LOAD;
  logic [POS_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [STORE_AW-1:0] node_index = '0;
  logic [B_W-1:0] node_bx = '0, node_by = '0, node_bz = '0;
  logic done, inside_res;
  logic [B_W-1:0] out_bx, out_by, out_bz;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [POS_W-1:0] cfg_data = '0;

  // Predictor state: grid contents and register copies.
  logic signed [B_W-1:0] grid_b [3][STORE_DEPTH];
  longint origin_q [3];
  longint spacing_q [3];
  field_t pending_fields [$];
  int mismatches = 0;
  int idle_pct = 0;
  int quiet_cycles = 0;

  trilinear_vector_field_lookup_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .node_index(node_index),
    .node_bx(node_bx), .node_by(node_by), .node_bz(node_bz),
    .done(done), .inside_res(inside_res), .out_bx(out_bx), .out_by(out_by),
    .out_bz(out_bz), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic bit locate_axis(input longint pos, input int ax,
                                     output longint cix, output longint frac);
    longint h, d, i;
    h = spacing_q[ax];
    if (h == 0) h = 1;
    d = pos - origin_q[ax];
    cix = 0;
    frac = 0;
    if (d < 0 || d > 31 * h) return 1'b0;
    i = d / h;
    if (i > 30) i = 30;
    cix = i;
    frac = ((d - i * h) * 65536) / h;
    return 1'b1;
  endfunction

  function automatic field_t interpolate_field(input logic [POS_W-1:0] px, py, pz);
    field_t f;
    longint cix [3];
    longint frac [3];
    longint b0, b1, vy0, vy1, y32, vx [2], x32, r;
    int addr;
    logic [B_W-1:0] comp [3];
    f.in_grid = 1'b0;
    f.bx = '0;
    f.by = '0;
    f.bz = '0;
    if (!locate_axis(longint'($signed(px)), 0, cix[0], frac[0])) return f;
    if (!locate_axis(longint'($signed(py)), 1, cix[1], frac[1])) return f;
    if (!locate_axis(longint'($signed(pz)), 2, cix[2], frac[2])) return f;
    for (int c = 0; c < 3; c++) begin
      for (int dx = 0; dx < 2; dx++) begin
        for (int dy = 0; dy < 2; dy++) begin
          addr = int'(((cix[0] + dx) * NY + cix[1] + dy) * NZ + cix[2]);
          b0 = longint'(grid_b[c][addr]);
          b1 = longint'(grid_b[c][addr + 1]);
          if (dy == 0) vy0 = b0 * (65536 - frac[2]) + b1 * frac[2];
          else vy1 = b0 * (65536 - frac[2]) + b1 * frac[2];
        end
        y32 = vy0 * (65536 - frac[1]) + vy1 * frac[1];
        vx[dx] = (y32 + 32768) >>> 16;
      end
      x32 = vx[0] * (65536 - frac[0]) + vx[1] * frac[0];
      r = (x32 + (longint'(1) <<< 31)) >>> 32;
      comp[c] = r[B_W-1:0];
    end
    f.in_grid = 1'b1;
    f.bx = comp[0];
    f.by = comp[1];
    f.bz = comp[2];
    return f;
  endfunction

  task automatic send_item(input logic act, input logic [POS_W-1:0] px, py, pz,
                           input logic [STORE_AW-1:0] idx,
                           input logic [B_W-1:0] bx, by, bz);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    action <= act;
    pos_x <= px;
    pos_y <= py;
    pos_z <= pz;
    node_index <= idx;
    node_bx <= bx;
    node_by <= by;
    node_bz <= bz;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    if (act == ACT_LOAD) begin
      grid_b[0][idx] = bx;
      grid_b[1][idx] = by;
      grid_b[2][idx] = bz;
    end else begin
      pending_fields.push_back(interpolate_field(px, py, pz));
    end
  endtask

  task automatic load_node(input int idx, input logic [B_W-1:0] bx, by, bz);
    send_item(ACT_LOAD, $urandom, $urandom, $urandom, idx[STORE_AW-1:0], bx, by, bz);
  endtask

  task automatic query_at(input logic [POS_W-1:0] px, py, pz);
    send_item(ACT_QUERY, px, py, pz, STORE_AW'($urandom), B_W'($urandom),
              B_W'($urandom), B_W'($urandom));
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_fields.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [POS_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx <= REG_ORIGIN_Z) origin_q[idx] = longint'($signed(data));
    else if (idx <= REG_SPACING_Z) spacing_q[idx - REG_SPACING_X] = longint'(data[SPC_W-1:0]);
  endtask

  task automatic set_grid(input longint ox, oy, oz, input logic [POS_W-1:0] sx, sy, sz);
    wait_idle();
    write_reg(REG_ORIGIN_X, ox[POS_W-1:0]);
    write_reg(REG_ORIGIN_Y, oy[POS_W-1:0]);
    write_reg(REG_ORIGIN_Z, oz[POS_W-1:0]);
    write_reg(REG_SPACING_X, sx);
    write_reg(REG_SPACING_Y, sy);
    write_reg(REG_SPACING_Z, sz);
  endtask

  // Only the three lowest and three highest nodes of each axis are loaded up front.
  function automatic int window_node(input int k, input int n);
    return (k < 3) ? k : n - 6 + k;
  endfunction

  // A random position that lies outside the grid along this axis.
  function automatic logic [POS_W-1:0] outside_pos(input int ax);
    longint h, d;
    logic [POS_W-1:0] p;
    h = spacing_q[ax];
    if (h == 0) h = 1;
    p = $urandom;
    d = longint'($signed(p)) - origin_q[ax];
    while (d >= 0 && d <= 31 * h) begin
      p = $urandom;
      d = longint'($signed(p)) - origin_q[ax];
    end
    return p;
  endfunction

  // Mostly points in the loaded cells near either end of the axis; the rest outside.
  function automatic logic [POS_W-1:0] pick_pos(input int ax);
    longint h, p;
    h = spacing_q[ax];
    if (h == 0) h = 1;
    if ($urandom_range(99) < 12) return outside_pos(ax);
    case ($urandom_range(9))
      0: p = origin_q[ax] + 31 * h;
      1: p = origin_q[ax] + h * $urandom_range(1);
      2: p = origin_q[ax] - $urandom_range(1, 3);
      3: p = origin_q[ax] + 31 * h + $urandom_range(1, 3);
      4, 5, 6: p = origin_q[ax] + longint'($urandom_range(0, 2 * h - 1));
      default: p = origin_q[ax] + 29 * h + longint'($urandom_range(0, 2 * h));
    endcase
    if (p > 64'sd2147483647 || p < -64'sd2147483648) return outside_pos(ax);
    return p[POS_W-1:0];
  endfunction

  task automatic test_fill_grid();
    idle_pct = 0;
    for (int i = 0; i < 6; i++)
      for (int j = 0; j < 6; j++)
        for (int k = 0; k < 6; k++)
          load_node((window_node(i, NX) * NY + window_node(j, NY)) * NZ + window_node(k, NZ),
                    B_W'($urandom), B_W'($urandom), B_W'($urandom));
  endtask

  task automatic test_directed();
    idle_pct = 0;
    load_node(0, 24'h7fffff, 24'h800000, 24'h7fffff);
    load_node(1, 24'h800000, 24'h7fffff, 24'h800000);
    load_node(NY * NZ, 24'h7fffff, 24'h7fffff, 24'h800000);
    load_node(STORE_DEPTH - 1, 24'h800000, 24'h800000, 24'h800000);
    query_at(0, 0, 0);
    query_at(128, 64, 200);
    query_at(7936, 7936, 7936);
    query_at(7935, 7936, 1);
    query_at(7937, 0, 0);
    query_at(0, 7937, 0);
    query_at(0, 0, 7937);
    query_at(32'hffffffff, 0, 0);
    query_at(0, 32'hffffffff, 0);
    query_at(0, 0, 32'hffffffff);
    query_at(32'h80000000, 32'h7fffffff, 0);
    query_at(32'h7fffffff, 32'h80000000, 32'h7fffffff);
    query_at(256, 256, 256);
    query_at(7900, 100, 7500);
    // Indexes beyond the last register must leave the grid unchanged.
    wait_idle();
    write_reg(3'd6, 32'h00001234);
    write_reg(3'd7, 32'hffffffff);
    query_at(0, 0, 0);
    query_at(300, 7500, 7936);
  endtask

  task automatic test_random(input int n, input int pct);
    idle_pct = pct;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 30)
        load_node($urandom_range(STORE_DEPTH - 1), B_W'($urandom), B_W'($urandom),
                  B_W'($urandom));
      else
        query_at(pick_pos(0), pick_pos(1), pick_pos(2));
    end
  endtask

  always @(posedge clk) begin
    field_t want;
    if (!rst && done) begin
      if (pending_fields.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
      end else begin
        want = pending_fields.pop_front();
        if (inside_res !== want.in_grid || out_bx !== want.bx || out_by !== want.by ||
            out_bz !== want.bz) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: expected %b %h %h %h, got %b %h %h %h",
                     $realtime, want.in_grid, want.bx, want.by, want.bz,
                     inside_res, out_bx, out_by, out_bz);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int a = 0; a < 3; a++) begin
      origin_q[a] = 0;
      spacing_q[a] = 256;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fill_grid();
    test_directed();
    test_random(280, 0);
    set_grid(-5000, 1234567, -99, 32'hfe000100, 100, 7);
    test_random(280, 88);
    set_grid(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
             32'h01000000, 32'h01000000, 32'h01000000);
    test_random(280, 0);
    set_grid(64'sd2147483647, 64'sd2147483647 - 31, 0, 0, 1, 32'h00000000);
    test_random(280, 34);
    set_grid(-($urandom_range(1 << 20)), $urandom_range(1 << 20), $urandom,
             $urandom_range(1, 1 << 24), $urandom_range(1, 4096), $urandom_range(1, 300));
    test_random(280, 88);
    wait_idle();
    if (mismatches == 0 && pending_fields.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
